@@ rtl/core/template_tag_tokenizer_top_assert.svh @@
// Assertion macros shared by the tokenizer modules.
`ifndef TEMPLATE_TAG_TOKENIZER_TOP_ASSERT_SVH
`define TEMPLATE_TAG_TOKENIZER_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define TTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define TTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ttt_pkg.sv @@
`default_nettype none
package ttt_pkg;

	// Event kinds.
	localparam logic [2:0] EV_TEXT  = 3'd0;
	localparam logic [2:0] EV_NODE  = 3'd1;
	localparam logic [2:0] EV_TRIM  = 3'd2;
	localparam logic [2:0] EV_ERROR = 3'd3;
	localparam logic [2:0] EV_END   = 3'd4;

	// One result item.
	typedef struct packed {
		logic [2:0]  event_kind;
		logic [3:0]  node_kind;
		logic [2:0]  compare_op;
		logic [15:0] first_begin;
		logic [15:0] first_finish;
		logic [15:0] second_begin;
		logic [15:0] second_finish;
		logic        strip_leading;
		logic [4:0]  error_code;
		logic [15:0] error_position;
		logic        last_of_run;
	} result_t;

	// One input item.
	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_source;
	} source_t;

	// Work handed from the scanner to the emitter: up to two results.
	typedef struct packed {
		logic    two;
		result_t first;
		result_t second;
	} result_pair_t;

endpackage
`default_nettype wire

@@ rtl/core/ttt_if.sv @@
`default_nettype none
interface ttt_if #(
	parameter int WIDTH = 8
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ttt_scan.sv @@
`default_nettype none
module ttt_scan
	import ttt_pkg::*;
#(
	parameter int SOURCE_LIMIT = 65535,
	parameter int MAX_IF_DEPTH = 255,
	parameter int KEYWORD_CHARS = 13
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_ready,
	input  source_t      in_data,
	output logic         q_valid,
	input  wire          q_ready,
	output result_pair_t q_data
);
	localparam logic [4:0] P_TEXT = 5'd0, P_OPEN = 5'd1, P_START_WS = 5'd2,
		P_BLK_START = 5'd3, P_KEYWORD = 5'd4, P_NAME_START = 5'd5, P_NAME = 5'd6,
		P_IF_START = 5'd7, P_IF_VAR = 5'd8, P_OP_START = 5'd9, P_OP = 5'd10,
		P_OPND_START = 5'd11, P_STR_OPND = 5'd12, P_VAR_OPND = 5'd13,
		P_FE_START = 5'd14, P_FE_VAR = 5'd15, P_END_WS = 5'd16, P_BLK_END = 5'd17,
		P_VAR_START = 5'd18, P_VAR = 5'd19, P_VAR_END = 5'd20, P_CLOSE = 5'd21;
	localparam int F_BLOCK = 0, F_ELSE = 1, F_FOREACH = 2, F_BLK_FOREACH = 3,
		F_LSTRIP = 4, F_PREV_TEXT = 5;
	localparam int WCW = $clog2(KEYWORD_CHARS + 1);
	localparam int DW = $clog2(MAX_IF_DEPTH + 1);

	// Scanner state.
	logic [4:0]  phase_q;
	logic [31:0] pos_q;
	logic [15:0] tb_q, tf_q, ob_q, of_q, nb_q, nf_q;
	logic [3:0]  pnk_q;
	logic [7:0]  wc_q [KEYWORD_CHARS];
	logic [7:0]  oc_q [2];
	logic [7:0]  prev_q;
	logic [DW-1:0] depth_q, blk_depth_q;
	logic [5:0]  fl_q;
	logic        halted_q;

	// Next-state values.
	logic [4:0]  phase_d;
	logic [15:0] tb_d, tf_d, ob_d, of_d, nb_d, nf_d;
	logic [3:0]  pnk_d;
	logic [7:0]  wc_d [KEYWORD_CHARS];
	logic [7:0]  oc_d [2];
	logic [DW-1:0] depth_d, blk_depth_d;
	logic [5:0]  fl_d;
	result_t     r0, r1;
	logic        n_res, failed;

	logic        fire;
	logic [7:0]  c;
	logic        last;
	logic [15:0] pos16;
	logic [15:0] wlen;

	assign in_ready = !q_valid || q_ready;
	assign fire = in_valid && in_ready;
	assign c = in_data.char_code;
	assign last = in_data.end_of_source;
	assign pos16 = pos_q[15:0];
	assign wlen = pos16 - tb_q;

	function automatic logic is_space(input logic [7:0] x);
		return x == 8'h20 || (x >= 8'h09 && x <= 8'h0d);
	endfunction
	function automatic logic is_lower(input logic [7:0] x);
		return x >= "a" && x <= "z";
	endfunction
	function automatic logic is_upper(input logic [7:0] x);
		return x >= "A" && x <= "Z";
	endfunction
	function automatic logic is_ident(input logic [7:0] x);
		return is_upper(x) || (x >= "0" && x <= "9") || x == "_";
	endfunction

	// Keyword compare, the keyword packed into 16 bytes, against the stored characters.
	function automatic logic word_is(input logic [127:0] kw, input int len,
			input logic [15:0] wl, input logic [8*KEYWORD_CHARS-1:0] w);
		logic ok;
		ok = (wl == 16'(len)) && (len <= KEYWORD_CHARS);
		for (int i = 0; i < 16; i++) begin
			if (i < len && i < KEYWORD_CHARS)
				if (w[8*i +: 8] != kw[8*(len-1-i) +: 8]) ok = 1'b0;
		end
		return ok;
	endfunction

	logic [8*KEYWORD_CHARS-1:0] wflat;
	always_comb begin
		for (int i = 0; i < KEYWORD_CHARS; i++) wflat[8*i +: 8] = wc_q[i];
	end

	logic k_block, k_endblock, k_ifdef, k_ifndef, k_if, k_else, k_endif, k_foreach,
		k_endforeach, k_name;
	assign k_block = word_is(128'("block"), 5, wlen, wflat);
	assign k_endblock = word_is(128'("endblock"), 8, wlen, wflat);
	assign k_ifdef = word_is(128'("ifdef"), 5, wlen, wflat);
	assign k_ifndef = word_is(128'("ifndef"), 6, wlen, wflat);
	assign k_if = word_is(128'("if"), 2, wlen, wflat);
	assign k_else = word_is(128'("else"), 4, wlen, wflat);
	assign k_endif = word_is(128'("endif"), 5, wlen, wflat);
	assign k_foreach = word_is(128'("foreach"), 7, wlen, wflat);
	assign k_endforeach = word_is(128'("endforeach"), 10, wlen, wflat);
	assign k_name = word_is(128'("entry"), 5, wlen, wflat)
		|| word_is(128'("listing"), 7, wlen, wflat)
		|| word_is(128'({"listing", "_once"}), 12, wlen, wflat)
		|| word_is(128'({"listing", "_empty"}), 13, wlen, wflat)
		|| word_is(128'({"listing", "_entry"}), 13, wlen, wflat);

	logic if_open;
	assign if_open = fl_q[F_BLOCK] ? (depth_q > blk_depth_q) : (depth_q != '0);

	// Operator decode from the captured characters.
	logic [2:0] op_dec;
	always_comb begin
		logic [15:0] len;
		len = of_q - ob_q;
		op_dec = 3'd0;
		if (len == 16'd1) begin
			if (oc_q[0] == "<") op_dec = 3'd1;
			else if (oc_q[0] == ">") op_dec = 3'd2;
		end else if (len == 16'd2 && oc_q[1] == "=") begin
			if (oc_q[0] == "<") op_dec = 3'd3;
			else if (oc_q[0] == ">") op_dec = 3'd4;
			else if (oc_q[0] == "=") op_dec = 3'd5;
			else if (oc_q[0] == "!") op_dec = 3'd6;
		end
	end

	// Byte classification and state update.
	always_comb begin
		result_t tmp;
		logic    do_err;
		logic [4:0] ecode;
		logic [15:0] epos;
		logic    do_text;
		logic [15:0] text_end;
		logic    do_trim, do_node;
		logic [2:0] nop;
		phase_d = phase_q; tb_d = tb_q; tf_d = tf_q; ob_d = ob_q; of_d = of_q;
		nb_d = nb_q; nf_d = nf_q; pnk_d = pnk_q; wc_d = wc_q; oc_d = oc_q;
		depth_d = depth_q; blk_depth_d = blk_depth_q; fl_d = fl_q;
		do_err = 1'b0; ecode = '0; epos = '0;
		do_text = 1'b0; text_end = '0; do_trim = 1'b0; do_node = 1'b0; nop = '0;
		tmp = '0;
		r0 = '0; r1 = '0; n_res = 1'b0;

		if (pos_q >= 32'(SOURCE_LIMIT)) begin
			do_err = 1'b1; ecode = 5'd30; epos = pos16;
		end else begin
			case (phase_q)
				P_TEXT: begin
					if (last) begin
						do_text = 1'b1; text_end = pos16 + 16'd1;
					end
					if (c == "{") begin
						tf_d = pos16; phase_d = P_OPEN;
					end
				end
				P_OPEN: begin
					if (c == "%" || c == "{") begin
						phase_d = (c == "%") ? P_START_WS : P_VAR_START;
						if (tf_q > tb_q) begin
							do_text = 1'b1; text_end = tf_q;
						end
					end else phase_d = P_TEXT;
				end
				P_START_WS, P_BLK_START: begin
					if (phase_q == P_START_WS && c == "-") begin
						phase_d = P_BLK_START;
						do_trim = fl_q[F_PREV_TEXT];
					end else begin
						if (phase_q == P_START_WS) phase_d = P_BLK_START;
						if (is_space(c)) begin
						end else if (is_lower(c)) begin
							phase_d = P_KEYWORD; tb_d = pos16; wc_d[0] = c;
						end else begin
							do_err = 1'b1; ecode = (c == "-") ? 5'd1 : 5'd2; epos = pos16;
						end
					end
				end
				P_KEYWORD: begin
					if (is_lower(c)) begin
						if (wlen < 16'(KEYWORD_CHARS)) wc_d[wlen[WCW-1:0]] = c;
					end else if (is_space(c) && k_block) begin
						if (fl_q[F_BLOCK]) begin
							do_err = 1'b1; ecode = 5'd3; epos = pos16;
						end else begin
							phase_d = P_NAME_START; pnk_d = 4'd1; tb_d = pos16;
							blk_depth_d = depth_q; fl_d[F_BLK_FOREACH] = fl_q[F_FOREACH];
						end
					end else if (is_space(c) && k_endblock) begin
						if (!fl_q[F_BLOCK]) begin
							do_err = 1'b1; ecode = 5'd6; epos = pos16;
						end else if (depth_q != blk_depth_q) begin
							do_err = 1'b1; ecode = 5'd4;
						end else if (!fl_q[F_BLK_FOREACH] && fl_q[F_FOREACH]) begin
							do_err = 1'b1; ecode = 5'd5;
						end else begin
							phase_d = P_END_WS; pnk_d = 4'd2; fl_d[F_BLOCK] = 1'b0;
						end
					end else if (is_space(c) && (k_ifdef || k_ifndef || k_if)) begin
						if (depth_q >= DW'(MAX_IF_DEPTH)) begin
							do_err = 1'b1; ecode = 5'd30; epos = pos16;
						end else begin
							phase_d = P_IF_START;
							pnk_d = k_ifdef ? 4'd3 : (k_ifndef ? 4'd4 : 4'd5);
							tb_d = pos16; depth_d = depth_q + 1'b1; fl_d[F_ELSE] = 1'b0;
						end
					end else if (is_space(c) && k_else) begin
						if (!if_open) begin
							do_err = 1'b1; ecode = 5'd8; epos = pos16;
						end else if (fl_q[F_ELSE]) begin
							do_err = 1'b1; ecode = 5'd7; epos = pos16;
						end else begin
							phase_d = P_END_WS; pnk_d = 4'd6; fl_d[F_ELSE] = 1'b1;
						end
					end else if (is_space(c) && k_endif) begin
						if (!if_open) begin
							do_err = 1'b1; ecode = 5'd9; epos = pos16;
						end else begin
							phase_d = P_END_WS; pnk_d = 4'd7; depth_d = depth_q - 1'b1;
							fl_d[F_ELSE] = 1'b0;
						end
					end else if (is_space(c) && k_foreach) begin
						if (fl_q[F_FOREACH]) begin
							do_err = 1'b1; ecode = 5'd10; epos = pos16;
						end else begin
							phase_d = P_FE_START; pnk_d = 4'd8; tb_d = pos16;
							fl_d[F_FOREACH] = 1'b1;
						end
					end else if (is_space(c) && k_endforeach) begin
						if (!fl_q[F_FOREACH] || (fl_q[F_BLOCK] && fl_q[F_BLK_FOREACH])) begin
							do_err = 1'b1; ecode = 5'd11; epos = pos16;
						end else begin
							phase_d = P_END_WS; pnk_d = 4'd9; fl_d[F_FOREACH] = 1'b0;
						end
					end else begin
						do_err = 1'b1; ecode = 5'd12; epos = pos16;
					end
				end
				P_NAME_START: begin
					if (is_space(c)) begin
					end else if (is_lower(c)) begin
						phase_d = P_NAME; tb_d = pos16; wc_d[0] = c;
					end else begin
						do_err = 1'b1; ecode = 5'd13; epos = pos16;
					end
				end
				P_NAME: begin
					if (is_lower(c) || c == "_") begin
						if (wlen < 16'(KEYWORD_CHARS)) wc_d[wlen[WCW-1:0]] = c;
					end else if (is_space(c) && k_name) begin
						fl_d[F_BLOCK] = 1'b1; tf_d = pos16; phase_d = P_END_WS;
					end else begin
						do_err = 1'b1; ecode = 5'd14; epos = pos16;
					end
				end
				P_IF_START, P_FE_START, P_VAR_START: begin
					if (is_space(c)) begin
					end else if (is_upper(c)) begin
						tb_d = pos16;
						if (phase_q == P_IF_START) phase_d = P_IF_VAR;
						else if (phase_q == P_FE_START) phase_d = P_FE_VAR;
						else begin
							phase_d = P_VAR; pnk_d = 4'd10;
						end
					end else begin
						do_err = 1'b1; ecode = (phase_q == P_FE_START) ? 5'd18 : 5'd15;
						epos = pos16;
					end
				end
				P_IF_VAR, P_FE_VAR: begin
					if (is_ident(c)) begin
					end else if (is_space(c)) begin
						tf_d = pos16;
						phase_d = (phase_q == P_IF_VAR && pnk_q == 4'd5) ? P_OP_START : P_END_WS;
					end else begin
						do_err = 1'b1; ecode = (phase_q == P_FE_VAR) ? 5'd19 : 5'd16;
						epos = pos16;
					end
				end
				P_OP_START: begin
					if (!is_space(c)) begin
						phase_d = P_OP; ob_d = pos16; oc_d[0] = c;
					end
				end
				P_OP: begin
					if (!is_space(c)) begin
						if (pos16 - ob_q == 16'd1) oc_d[1] = c;
						else if (pos16 == ob_q) oc_d[0] = c;
					end else begin
						phase_d = P_OPND_START; of_d = pos16;
					end
				end
				P_OPND_START: begin
					if (is_space(c)) begin
					end else if (is_upper(c) || c == "\"") begin
						phase_d = is_upper(c) ? P_VAR_OPND : P_STR_OPND; nb_d = pos16;
					end else begin
						ob_d = '0; of_d = '0;
						do_err = 1'b1; ecode = 5'd17; epos = pos16;
					end
				end
				P_STR_OPND: begin
					if (c == "\"" && prev_q != "\\") begin
						phase_d = P_END_WS; nf_d = pos16 + 16'd1;
					end
				end
				P_VAR_OPND: begin
					if (!is_ident(c)) begin
						phase_d = P_END_WS; nf_d = pos16;
					end
				end
				P_END_WS, P_BLK_END: begin
					if (phase_q == P_END_WS && is_space(c)) begin
					end else if (phase_q == P_END_WS && c == "-") begin
						fl_d[F_LSTRIP] = 1'b1; phase_d = P_BLK_END;
					end else if (c == "%") begin
						phase_d = P_CLOSE;
					end else begin
						phase_d = P_BLK_END;
						do_err = 1'b1; ecode = (c == "-") ? 5'd20 : 5'd21; epos = pos16;
					end
				end
				P_VAR: begin
					if (is_ident(c)) begin
					end else if (is_space(c) || c == "}") begin
						tf_d = pos16; phase_d = (c == "}") ? P_CLOSE : P_VAR_END;
					end else begin
						do_err = 1'b1; ecode = 5'd16; epos = pos16;
					end
				end
				P_VAR_END: begin
					if (is_space(c)) begin
					end else if (c == "}") phase_d = P_CLOSE;
					else begin
						do_err = 1'b1; ecode = 5'd22; epos = pos16;
					end
				end
				P_CLOSE: begin
					if (c != "}") begin
						do_err = 1'b1; ecode = 5'd23; epos = pos16;
					end else if (of_q > ob_q && op_dec == 3'd0) begin
						do_err = 1'b1; ecode = 5'd24; epos = ob_q; ob_d = '0; of_d = '0;
					end else begin
						if (of_q > ob_q) begin
							nop = op_dec; ob_d = '0; of_d = '0;
						end
						do_node = 1'b1;
						if (nf_q > nb_q) begin
							nb_d = '0; nf_d = '0;
						end
						fl_d[F_PREV_TEXT] = 1'b0; phase_d = P_TEXT; pnk_d = 4'd0;
						tb_d = pos16 + 16'd1;
					end
				end
				default: phase_d = P_TEXT;
			endcase
		end

		// First result of the byte, at most one of these.
		if (do_text) begin
			tmp = '0; tmp.event_kind = EV_TEXT; tmp.first_begin = tb_q;
			tmp.first_finish = text_end; tmp.strip_leading = fl_q[F_LSTRIP];
			fl_d[F_LSTRIP] = 1'b0; fl_d[F_PREV_TEXT] = 1'b1;
			r0 = tmp; n_res = 1'b1;
		end else if (do_trim) begin
			tmp = '0; tmp.event_kind = EV_TRIM; tmp.first_begin = tb_q;
			tmp.first_finish = tf_q;
			r0 = tmp; n_res = 1'b1;
		end else if (do_node) begin
			tmp = '0; tmp.event_kind = EV_NODE; tmp.node_kind = pnk_q; tmp.compare_op = nop;
			tmp.first_begin = tb_q; tmp.first_finish = tf_q;
			tmp.second_begin = nb_q; tmp.second_finish = nf_q;
			r0 = tmp; n_res = 1'b1;
		end
		failed = do_err;

		// Error or end-of-source checks: second result when one already exists.
		tmp = '0;
		if (do_err) begin
			tmp.event_kind = EV_ERROR; tmp.error_code = ecode; tmp.error_position = epos;
		end else if (last) begin
			if (phase_d == P_STR_OPND) begin
				tmp.event_kind = EV_ERROR; tmp.error_code = 5'd25; tmp.error_position = nb_d;
			end else if (depth_d != '0) begin
				tmp.event_kind = EV_ERROR; tmp.error_code = 5'd26;
			end else if (fl_d[F_BLOCK]) begin
				tmp.event_kind = EV_ERROR; tmp.error_code = 5'd27;
			end else if (fl_d[F_FOREACH]) begin
				tmp.event_kind = EV_ERROR; tmp.error_code = 5'd28;
			end else tmp.event_kind = EV_END;
		end
		if (do_err || last) begin
			if (n_res) r1 = tmp;
			else r0 = tmp;
		end
	end

	// Results passed to the queue; an empty pair is dropped.
	logic has_any, two;
	result_t r0_m, r1_m;
	assign two = n_res && (failed || last);
	assign has_any = !halted_q && (n_res || failed || last);

	// The final mark goes on the last result of the byte.
	always_comb begin
		r0_m = r0;
		r0_m.last_of_run = !two;
		r1_m = r1;
		r1_m.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else if (in_ready) begin
			q_valid <= fire && has_any;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			q_data.two <= two;
			q_data.first <= r0_m;
			q_data.second <= r1_m;
		end
	end

	// State registers; the final byte or an error ends the template.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_TEXT; pos_q <= '0; tb_q <= '0; tf_q <= '0; ob_q <= '0;
			of_q <= '0; nb_q <= '0; nf_q <= '0; pnk_q <= '0; oc_q <= '{default: '0};
			wc_q <= '{default: '0}; prev_q <= '0; depth_q <= '0; blk_depth_q <= '0;
			fl_q <= '0; halted_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				phase_q <= P_TEXT; pos_q <= '0; tb_q <= '0; tf_q <= '0; ob_q <= '0;
				of_q <= '0; nb_q <= '0; nf_q <= '0; pnk_q <= '0; oc_q <= '{default: '0};
				wc_q <= '{default: '0}; prev_q <= '0; depth_q <= '0; blk_depth_q <= '0;
				fl_q <= '0; halted_q <= 1'b0;
			end else if (halted_q) begin
			end else if (failed) begin
				halted_q <= 1'b1;
			end else begin
				phase_q <= phase_d; pos_q <= pos_q + 32'd1; tb_q <= tb_d; tf_q <= tf_d;
				ob_q <= ob_d; of_q <= of_d; nb_q <= nb_d; nf_q <= nf_d; pnk_q <= pnk_d;
				wc_q <= wc_d; oc_q <= oc_d; prev_q <= c; depth_q <= depth_d;
				blk_depth_q <= blk_depth_d; fl_q <= fl_d;
			end
		end
	end

	`include "template_tag_tokenizer_top_assert.svh"
	`TTT_ASSERT_NEXT(a_halt_silent, clk, arst_n, fire && halted_q && !last, !q_valid,
		"halted scanner produced a result")
	`TTT_ASSERT_IMP(a_depth_bound, clk, arst_n, 1'b1, depth_q <= DW'(MAX_IF_DEPTH),
		"if depth beyond limit")
	`TTT_ASSERT_NEXT(a_last_ends, clk, arst_n, fire && last && !halted_q, q_valid,
		"final byte gave no result")
endmodule
`default_nettype wire

@@ rtl/core/ttt_emit.sv @@
`default_nettype none
module ttt_emit
	import ttt_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          q_valid,
	output logic         q_ready,
	input  result_pair_t q_data,
	output logic         out_valid,
	input  wire          out_ready,
	output result_t      out_data
);
	// Sends the first result, then the second when the pair has one.
	logic sel_q;

	assign out_valid = q_valid;
	assign out_data = sel_q ? q_data.second : q_data.first;
	assign q_ready = out_ready && (sel_q || !q_data.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (q_valid && out_ready) begin
			sel_q <= !sel_q && q_data.two;
		end
	end

	`include "template_tag_tokenizer_top_assert.svh"
	`TTT_ASSERT_IMP(a_sel_pair, clk, arst_n, sel_q, q_valid && q_data.two,
		"second result selected without a pair")
	`TTT_ASSERT_IMP(a_last_mark, clk, arst_n, out_valid && q_ready, out_data.last_of_run,
		"pair retired without final mark")
	`TTT_ASSERT_NEXT(a_hold, clk, arst_n, q_valid && !q_ready, q_valid,
		"queued pair lost")
endmodule
`default_nettype wire

@@ rtl/core/template_tag_tokenizer_top.sv @@
`default_nettype none
// Template tag tokenizer: takes one source byte per cycle on src while res is
// not holding it back, and gives text, tag, trim, error and end events on res.
// The scanner classifies each byte with its phase logic and parallel keyword
// compares, which set the rate of one byte a cycle; a byte that yields two
// results holds the scanner while the emitter sends the second.
module template_tag_tokenizer_top
	import ttt_pkg::*;
#(
	parameter int SOURCE_LIMIT = 65535,
	parameter int MAX_IF_DEPTH = 255,
	parameter int KEYWORD_CHARS = 13
) (
	input wire clk,
	input wire arst_n,
	ttt_if.sink   src,
	ttt_if.source res
);
	logic         q_valid, q_ready;
	result_pair_t q_data;
	result_t      r;

	ttt_scan #(
		.SOURCE_LIMIT(SOURCE_LIMIT), .MAX_IF_DEPTH(MAX_IF_DEPTH),
		.KEYWORD_CHARS(KEYWORD_CHARS)
	) u_scan (
		.clk(clk), .arst_n(arst_n),
		.in_valid(src.valid), .in_ready(src.ready), .in_data(source_t'(src.payload)),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	ttt_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(res.valid), .out_ready(res.ready), .out_data(r)
	);

	assign res.payload = r;
endmodule
`default_nettype wire

@@ tb/template_tag_tokenizer_top_tb.sv @@
`timescale 1ns / 100ps

import ttt_pkg::*;

// Scan phases of the tokenizer, as the scoreboard tracks them.
typedef enum int {
	PH_TEXT, PH_OPEN, PH_START_WS, PH_BLK_START, PH_KEYWORD, PH_NAME_START, PH_NAME,
	PH_IF_START, PH_IF_VAR, PH_OP_START, PH_OP, PH_OPND_START, PH_STR_OPND,
	PH_VAR_OPND, PH_FE_START, PH_FE_VAR, PH_END_WS, PH_BLK_END, PH_VAR_START,
	PH_VAR, PH_VAR_END, PH_CLOSE
} scan_phase_e;

// Node kinds.
localparam logic [3:0] NK_TEXT = 4'd0, NK_BLOCK = 4'd1, NK_ENDBLOCK = 4'd2,
	NK_IFDEF = 4'd3, NK_IFNDEF = 4'd4, NK_IF = 4'd5, NK_ELSE = 4'd6, NK_ENDIF = 4'd7,
	NK_FOREACH = 4'd8, NK_ENDFOREACH = 4'd9, NK_VARIABLE = 4'd10;

// Comparison operators.
localparam logic [2:0] OP_NONE = 3'd0, OP_LT = 3'd1, OP_GT = 3'd2, OP_LE = 3'd3,
	OP_GE = 3'd4, OP_EQ = 3'd5, OP_NE = 3'd6;

// Error codes.
localparam logic [4:0] ERR_DASH_BEFORE = 5'd1, ERR_STMT_CASE = 5'd2,
	ERR_NESTED_BLOCK = 5'd3, ERR_BLOCK_IF_OPEN = 5'd4, ERR_BLOCK_FE_OPEN = 5'd5,
	ERR_ENDBLOCK = 5'd6, ERR_SECOND_ELSE = 5'd7, ERR_ELSE = 5'd8, ERR_ENDIF = 5'd9,
	ERR_NESTED_FE = 5'd10, ERR_ENDFOREACH = 5'd11, ERR_UNKNOWN_STMT = 5'd12,
	ERR_NAME_CASE = 5'd13, ERR_BLOCK_NAME = 5'd14, ERR_VAR_START = 5'd15,
	ERR_VAR_CHAR = 5'd16, ERR_IF_OPERAND = 5'd17, ERR_FE_VAR_START = 5'd18,
	ERR_FE_VAR_CHAR = 5'd19, ERR_DASH_AFTER = 5'd20, ERR_NO_STMT_CLOSE = 5'd21,
	ERR_NO_VAR_CLOSE = 5'd22, ERR_NO_BRACE = 5'd23, ERR_IF_OPERATOR = 5'd24,
	ERR_OPEN_STRING = 5'd25, ERR_IF_AT_END = 5'd26, ERR_BLOCK_AT_END = 5'd27,
	ERR_FE_AT_END = 5'd28, ERR_OVERFLOW = 5'd30;

localparam int unsigned SRC_LIMIT = 65535;
localparam int unsigned IF_LIMIT = 255;
localparam int unsigned WORD_CHARS = 13;

// Scoreboard: predicts the events of each accepted byte and checks results in order.
class tokenizer_scoreboard;
	scan_phase_e phase;
	int unsigned pos, txt_b, txt_f, opr_b, opr_f, opd_b, opd_f;
	logic [3:0] pend_kind;
	byte unsigned word[WORD_CHARS];
	byte unsigned op_chars[2];
	byte unsigned prev;
	int unsigned if_depth, if_at_block;
	bit f_block, f_else, f_fe, f_blk_fe, f_strip, f_prev_text, halted;
	bit step_failed;
	result_t step_events[$];
	result_t expected_events[$];
	int n_results, n_nodes, n_errors, n_ends, n_failures;

	function new();
		clear_state();
	endfunction

	function void clear_state();
		phase = PH_TEXT;
		pos = 0; txt_b = 0; txt_f = 0; opr_b = 0; opr_f = 0; opd_b = 0; opd_f = 0;
		pend_kind = NK_TEXT;
		foreach (word[i]) word[i] = 0;
		op_chars[0] = 0; op_chars[1] = 0; prev = 0;
		if_depth = 0; if_at_block = 0;
		{f_block, f_else, f_fe, f_blk_fe, f_strip, f_prev_text, halted} = '0;
	endfunction

	function void push_event(logic [2:0] ev, logic [3:0] nk, logic [2:0] op,
			int unsigned fb, int unsigned ff, int unsigned sb, int unsigned sf,
			bit strip, logic [4:0] code, int unsigned epos);
		result_t r;
		if (step_events.size() >= 2) return;
		r = '0;
		r.event_kind = ev; r.node_kind = nk; r.compare_op = op;
		r.first_begin = fb[15:0]; r.first_finish = ff[15:0];
		r.second_begin = sb[15:0]; r.second_finish = sf[15:0];
		r.strip_leading = strip; r.error_code = code; r.error_position = epos[15:0];
		step_events.push_back(r);
	endfunction

	function void raise(logic [4:0] code, int unsigned epos);
		push_event(EV_ERROR, NK_TEXT, OP_NONE, 0, 0, 0, 0, 0, code, epos);
		step_failed = 1;
	endfunction

	function bit is_space(byte unsigned c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction
	function bit is_lower(byte unsigned c);
		return c >= "a" && c <= "z";
	endfunction
	function bit is_upper(byte unsigned c);
		return c >= "A" && c <= "Z";
	endfunction
	function bit is_ident(byte unsigned c);
		return is_upper(c) || (c >= "0" && c <= "9") || c == "_";
	endfunction

	function void keep_char(byte unsigned c);
		int unsigned i;
		i = pos - txt_b;
		if (i < WORD_CHARS) word[i] = c;
	endfunction

	// The word gathered since txt_b matches kw exactly.
	function bit word_is(string kw);
		int unsigned n;
		n = kw.len();
		if (pos - txt_b != n || n > WORD_CHARS) return 0;
		for (int i = 0; i < n; i++)
			if (word[i] != kw[i]) return 0;
		return 1;
	endfunction

	function bit if_open();
		return f_block ? (if_depth > if_at_block) : (if_depth > 0);
	endfunction

	function void block_start(byte unsigned c);
		if (is_space(c)) return;
		if (is_lower(c)) begin
			phase = PH_KEYWORD; txt_b = pos; word[0] = c;
		end else begin
			raise(c == "-" ? ERR_DASH_BEFORE : ERR_STMT_CASE, pos);
		end
	endfunction

	function void block_end(byte unsigned c);
		if (c == "%") phase = PH_CLOSE;
		else raise(c == "-" ? ERR_DASH_AFTER : ERR_NO_STMT_CLOSE, pos);
	endfunction

	function void open_if(logic [3:0] kind);
		if (if_depth >= IF_LIMIT) begin
			raise(ERR_OVERFLOW, pos);
			return;
		end
		phase = PH_IF_START; pend_kind = kind; txt_b = pos;
		if_depth++; f_else = 0;
	endfunction

	function void keyword(byte unsigned c);
		if (is_lower(c)) begin
			keep_char(c);
			return;
		end
		if (is_space(c)) begin
			if (word_is("block")) begin
				if (f_block) begin raise(ERR_NESTED_BLOCK, pos); return; end
				phase = PH_NAME_START; pend_kind = NK_BLOCK; txt_b = pos;
				if_at_block = if_depth; f_blk_fe = f_fe;
				return;
			end
			if (word_is("endblock")) begin
				if (!f_block) begin raise(ERR_ENDBLOCK, pos); return; end
				if (if_depth != if_at_block) begin raise(ERR_BLOCK_IF_OPEN, 0); return; end
				if (!f_blk_fe && f_fe) begin raise(ERR_BLOCK_FE_OPEN, 0); return; end
				phase = PH_END_WS; pend_kind = NK_ENDBLOCK; f_block = 0;
				return;
			end
			if (word_is("ifdef")) begin open_if(NK_IFDEF); return; end
			if (word_is("ifndef")) begin open_if(NK_IFNDEF); return; end
			if (word_is("if")) begin open_if(NK_IF); return; end
			if (word_is("else")) begin
				if (!if_open()) begin raise(ERR_ELSE, pos); return; end
				if (f_else) begin raise(ERR_SECOND_ELSE, pos); return; end
				phase = PH_END_WS; pend_kind = NK_ELSE; f_else = 1;
				return;
			end
			if (word_is("endif")) begin
				if (!if_open()) begin raise(ERR_ENDIF, pos); return; end
				phase = PH_END_WS; pend_kind = NK_ENDIF; if_depth--; f_else = 0;
				return;
			end
			if (word_is("foreach")) begin
				if (f_fe) begin raise(ERR_NESTED_FE, pos); return; end
				phase = PH_FE_START; pend_kind = NK_FOREACH; txt_b = pos; f_fe = 1;
				return;
			end
			if (word_is("endforeach")) begin
				if (!((f_block && !f_blk_fe && f_fe) || (!f_block && f_fe))) begin
					raise(ERR_ENDFOREACH, pos);
					return;
				end
				phase = PH_END_WS; pend_kind = NK_ENDFOREACH; f_fe = 0;
				return;
			end
		end
		raise(ERR_UNKNOWN_STMT, pos);
	endfunction

	function void block_name(byte unsigned c);
		if (is_lower(c) || c == "_") begin
			keep_char(c);
			return;
		end
		if (is_space(c) && (word_is("entry") || word_is("listing") ||
				word_is({"listing", "_once"}) || word_is({"listing", "_empty"}) ||
				word_is({"listing", "_entry"}))) begin
			f_block = 1; txt_f = pos; phase = PH_END_WS;
			return;
		end
		raise(ERR_BLOCK_NAME, pos);
	endfunction

	function logic [2:0] operator_code();
		int unsigned n;
		n = opr_f - opr_b;
		if (n == 1) begin
			if (op_chars[0] == "<") return OP_LT;
			if (op_chars[0] == ">") return OP_GT;
		end else if (n == 2 && op_chars[1] == "=") begin
			if (op_chars[0] == "<") return OP_LE;
			if (op_chars[0] == ">") return OP_GE;
			if (op_chars[0] == "=") return OP_EQ;
			if (op_chars[0] == "!") return OP_NE;
		end
		return OP_NONE;
	endfunction

	function void close_tag(byte unsigned c);
		logic [2:0] op;
		op = OP_NONE;
		if (c != "}") begin
			raise(ERR_NO_BRACE, pos);
			return;
		end
		if (opr_f > opr_b) begin
			op = operator_code();
			if (op == OP_NONE) begin
				raise(ERR_IF_OPERATOR, opr_b);
				opr_b = 0; opr_f = 0;
				return;
			end
			opr_b = 0; opr_f = 0;
		end
		push_event(EV_NODE, pend_kind, op, txt_b, txt_f, opd_b, opd_f, 0, 0, 0);
		if (opd_f > opd_b) begin opd_b = 0; opd_f = 0; end
		f_prev_text = 0; phase = PH_TEXT; pend_kind = NK_TEXT; txt_b = pos + 1;
	endfunction

	function void text_span(int unsigned fin);
		push_event(EV_TEXT, NK_TEXT, OP_NONE, txt_b, fin, 0, 0, f_strip, 0, 0);
		f_strip = 0; f_prev_text = 1;
	endfunction

	function void scan_byte(byte unsigned c, bit last);
		case (phase)
			PH_TEXT: begin
				if (last) text_span(pos + 1);
				if (c == "{") begin txt_f = pos; phase = PH_OPEN; end
			end
			PH_OPEN: begin
				if (c == "%" || c == "{") begin
					phase = (c == "%") ? PH_START_WS : PH_VAR_START;
					if (txt_f > txt_b) text_span(txt_f);
				end else begin
					phase = PH_TEXT;
				end
			end
			PH_START_WS: begin
				phase = PH_BLK_START;
				if (c == "-") begin
					if (f_prev_text)
						push_event(EV_TRIM, NK_TEXT, OP_NONE, txt_b, txt_f, 0, 0, 0, 0, 0);
				end else begin
					block_start(c);
				end
			end
			PH_BLK_START: block_start(c);
			PH_KEYWORD: keyword(c);
			PH_NAME_START: begin
				if (!is_space(c)) begin
					if (is_lower(c)) begin
						phase = PH_NAME; txt_b = pos; word[0] = c;
					end else begin
						raise(ERR_NAME_CASE, pos);
					end
				end
			end
			PH_NAME: block_name(c);
			PH_IF_START, PH_FE_START, PH_VAR_START: begin
				if (!is_space(c)) begin
					if (is_upper(c)) begin
						txt_b = pos;
						if (phase == PH_IF_START) phase = PH_IF_VAR;
						else if (phase == PH_FE_START) phase = PH_FE_VAR;
						else begin phase = PH_VAR; pend_kind = NK_VARIABLE; end
					end else begin
						raise(phase == PH_FE_START ? ERR_FE_VAR_START : ERR_VAR_START, pos);
					end
				end
			end
			PH_IF_VAR, PH_FE_VAR: begin
				if (!is_ident(c)) begin
					if (is_space(c)) begin
						txt_f = pos;
						phase = (phase == PH_IF_VAR && pend_kind == NK_IF) ?
							PH_OP_START : PH_END_WS;
					end else begin
						raise(phase == PH_FE_VAR ? ERR_FE_VAR_CHAR : ERR_VAR_CHAR, pos);
					end
				end
			end
			PH_OP_START: begin
				if (!is_space(c)) begin
					phase = PH_OP; opr_b = pos; op_chars[0] = c;
				end
			end
			PH_OP: begin
				if (!is_space(c)) begin
					if (pos - opr_b < 2) op_chars[pos - opr_b] = c;
				end else begin
					phase = PH_OPND_START; opr_f = pos;
				end
			end
			PH_OPND_START: begin
				if (!is_space(c)) begin
					if (is_upper(c) || c == "\"") begin
						phase = is_upper(c) ? PH_VAR_OPND : PH_STR_OPND;
						opd_b = pos;
					end else begin
						opr_b = 0; opr_f = 0;
						raise(ERR_IF_OPERAND, pos);
					end
				end
			end
			PH_STR_OPND: begin
				if (c == "\"" && prev != "\\") begin
					phase = PH_END_WS; opd_f = pos + 1;
				end
			end
			PH_VAR_OPND: begin
				if (!is_ident(c)) begin
					phase = PH_END_WS; opd_f = pos;
				end
			end
			PH_END_WS: begin
				if (!is_space(c)) begin
					phase = PH_BLK_END;
					if (c == "-") f_strip = 1;
					else block_end(c);
				end
			end
			PH_BLK_END: block_end(c);
			PH_VAR: begin
				if (!is_ident(c)) begin
					if (is_space(c) || c == "}") begin
						txt_f = pos;
						phase = (c == "}") ? PH_CLOSE : PH_VAR_END;
					end else begin
						raise(ERR_VAR_CHAR, pos);
					end
				end
			end
			PH_VAR_END: begin
				if (!is_space(c)) begin
					if (c == "}") phase = PH_CLOSE;
					else raise(ERR_NO_VAR_CLOSE, pos);
				end
			end
			PH_CLOSE: close_tag(c);
			default: phase = PH_TEXT;
		endcase
	endfunction

	// Notes one accepted request and queues the events it should cause.
	function void note_request(source_t req);
		byte unsigned c;
		bit last;
		c = req.char_code;
		last = req.end_of_source;
		step_events.delete();
		step_failed = 0;
		if (halted) begin
			if (last) clear_state();
			return;
		end
		if (pos >= SRC_LIMIT) raise(ERR_OVERFLOW, pos);
		else scan_byte(c, last);
		if (step_failed) begin
			if (last) clear_state();
			else halted = 1;
		end else begin
			prev = c;
			pos++;
			if (last) begin
				if (phase == PH_STR_OPND) raise(ERR_OPEN_STRING, opd_b);
				else if (if_depth != 0) raise(ERR_IF_AT_END, 0);
				else if (f_block) raise(ERR_BLOCK_AT_END, 0);
				else if (f_fe) raise(ERR_FE_AT_END, 0);
				else push_event(EV_END, NK_TEXT, OP_NONE, 0, 0, 0, 0, 0, 0, 0);
				clear_state();
			end
		end
		if (step_events.size() > 0) step_events[step_events.size() - 1].last_of_run = 1;
		foreach (step_events[i]) expected_events.push_back(step_events[i]);
	endfunction

	function void compare_field(string name, longint unsigned exp, longint unsigned act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			n_failures++;
		end
	endfunction

	// Checks one accepted result against the oldest expected event.
	function void check_result(result_t got);
		result_t exp;
		if (expected_events.size() == 0) begin
			$error("Result with no expected event: event_kind %0d", got.event_kind);
			n_failures++;
			return;
		end
		exp = expected_events.pop_front();
		n_results++;
		if (exp.event_kind == EV_NODE) n_nodes++;
		if (exp.event_kind == EV_ERROR) n_errors++;
		if (exp.event_kind == EV_END) n_ends++;
		compare_field("event_kind", exp.event_kind, got.event_kind);
		compare_field("node_kind", exp.node_kind, got.node_kind);
		compare_field("compare_op", exp.compare_op, got.compare_op);
		compare_field("first_begin", exp.first_begin, got.first_begin);
		compare_field("first_finish", exp.first_finish, got.first_finish);
		compare_field("second_begin", exp.second_begin, got.second_begin);
		compare_field("second_finish", exp.second_finish, got.second_finish);
		compare_field("strip_leading", exp.strip_leading, got.strip_leading);
		compare_field("error_code", exp.error_code, got.error_code);
		compare_field("error_position", exp.error_position, got.error_position);
		compare_field("last_of_run", exp.last_of_run, got.last_of_run);
	endfunction
endclass

module template_tag_tokenizer_top_tb;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int idle_pct = 33;
	int n_sources = 0;
	int n_bytes = 0;
	int quiet_cycles = 0;
	tokenizer_scoreboard sb = new();

	ttt_if #(.WIDTH($bits(source_t))) src_if ();
	ttt_if #(.WIDTH($bits(result_t))) res_if ();

	template_tag_tokenizer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_if),
		.res(res_if)
	);

	always #5 clk = ~clk;

	initial begin
		src_if.valid = 1'b0;
		src_if.payload = '0;
		res_if.ready = 1'b0;
	end

	// Result side: random back-pressure.
	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= idle_pct);
	end

	// Check every accepted result.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.payload);
	end

	// Watchdog on cycles with no request and no result accepted.
	always @(posedge clk) begin
		if ((src_if.valid && src_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Sends one byte and waits for it to be accepted.
	task automatic send_byte(byte unsigned c, bit last);
		source_t req;
		req.char_code = c;
		req.end_of_source = last;
		while ($urandom_range(99) < idle_pct) begin
			src_if.valid <= 1'b0;
			@(posedge clk);
		end
		src_if.valid <= 1'b1;
		src_if.payload <= req;
		do @(posedge clk); while (!src_if.ready);
		sb.note_request(req);
		n_bytes++;
	endtask

	// Sends a whole template, flagging its final byte.
	task automatic send_source(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
		n_sources++;
	endtask

	function automatic string pick(string opts[$]);
		return opts[$urandom_range(opts.size() - 1)];
	endfunction

	function automatic string rand_text();
		string s;
		int n;
		s = "";
		n = $urandom_range(0, 5);
		for (int i = 0; i < n; i++)
			s = {s, pick('{"a", "Z", " ", "\n", "\t", "x", "{", "}", "%", "-"})};
		return s;
	endfunction

	function automatic string open_stmt();
		return ($urandom_range(3) == 0) ? "{%- " : "{% ";
	endfunction

	function automatic string close_stmt();
		return ($urandom_range(3) == 0) ? " -%}" : " %}";
	endfunction

	function automatic string rand_var();
		return pick('{"A", "FOO", "X_1", "TITLE2", "B9_Z"});
	endfunction

	// Builds well-nested template content with random pieces.
	function automatic string rand_body(int depth, bit in_block, bit in_fe);
		string s, op, opnd;
		int n;
		s = rand_text();
		n = (depth > 2) ? 0 : $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(5))
				0: s = {s, "{{ ", rand_var(), pick('{" }}", "}}"})};
				1: begin
					op = pick('{"<", ">", "<=", ">=", "==", "!=", "<=", "=<", "="});
					opnd = ($urandom_range(1) == 0) ? rand_var() :
						pick('{"\"v\"", "\"a\\\"b\"", "\"\""});
					s = {s, open_stmt(), "if ", rand_var(), " ", op, " ", opnd,
						close_stmt(), rand_body(depth + 1, in_block, in_fe)};
					if ($urandom_range(1) == 0)
						s = {s, open_stmt(), "else", close_stmt(),
							rand_body(depth + 1, in_block, in_fe)};
					s = {s, open_stmt(), "endif", close_stmt()};
				end
				2: s = {s, open_stmt(), pick('{"ifdef ", "ifndef "}), rand_var(),
					close_stmt(), rand_body(depth + 1, in_block, in_fe),
					open_stmt(), "endif", close_stmt()};
				3: if (!in_fe)
					s = {s, open_stmt(), "foreach ", rand_var(), close_stmt(),
						rand_body(depth + 1, in_block, 1), open_stmt(), "endforeach",
						close_stmt()};
				4: if (!in_block)
					s = {s, open_stmt(), "block ",
						pick('{"entry", "listing", {"listing", "_once"},
							{"listing", "_empty"}, {"listing", "_entry"}}),
						close_stmt(), rand_body(depth + 1, 1, 0), open_stmt(), "endblock",
						close_stmt()};
				default: s = {s, rand_text()};
			endcase
			s = {s, rand_text()};
		end
		return s;
	endfunction

	// Random template: mostly well formed, some damaged, some pure noise.
	function automatic string rand_source();
		string s;
		int kind;
		kind = $urandom_range(99);
		if (kind < 12) begin
			s = "";
			for (int i = $urandom_range(1, 20); i > 0; i--)
				s = {s, string'(byte'($urandom_range(255)))};
			return s;
		end
		s = rand_body(0, 0, 0);
		if (kind < 35 && s.len() > 0) begin
			for (int i = $urandom_range(1, 2); i > 0; i--)
				s[$urandom_range(s.len() - 1)] = byte'($urandom_range(255));
		end
		if (s.len() == 0) s = "x";
		return s;
	endfunction

	initial begin
		string directed[$];
		directed = '{
			"hello",
			"a{{ FOO }}b",
			"{{BAR_9}}",
			"x {%- block entry -%} y {% endblock %}z",
			"{% if A == \"x\\\"y\" %}1{% else %}2{% endif %}",
			"{% if A < B %}{% endif %}{% if A > B %}{% endif %}{% if A <= \"q\" %}{% endif %}",
			"{% if A >= B %}{% endif %}{% if A != B %}{% endif %}",
			"{% if A =< B %}{% endif %}",
			"{% ifdef X %}{% else %}{% else %}{% endif %}",
			"{% ifndef Y %}t{% endif %}{% foreach L %}e{% endforeach %}",
			"{%-- if %}",
			"{% Block %}",
			"{% block Entry %}",
			{"{% block listing", "_entry %}{% block entry %}"},
			"{% block entry %}{% if A %}{% endblock %}",
			"{% block entry %}{% foreach L %}{% endblock %}",
			"{% endblock %}{% else %}",
			"{% endif %}",
			"{% foreach a %}",
			"{% if A == \"open",
			"{% ifdef A %}",
			"{% verylongkeywordname %}",
			"{{ foo }}{{ A! }}{{ A B }}{% if A %}x{% endif -%-",
			"{% if A == ? %}{% foreach L %}{% foreach M %}"
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_source(directed[i]);

		// Random templates up to the byte budget, the first stretch free of idling.
		for (int start = n_bytes; n_bytes < 950; ) begin
			idle_pct = (n_bytes - start < 150) ? 0 : 33;
			send_source(rand_source());
		end
		idle_pct = 33;
		src_if.valid <= 1'b0;

		while (sb.expected_events.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d templates (%0d bytes); checked %0d results:", n_sources, n_bytes,
			sb.n_results);
		$display("%0d tag nodes, %0d errors, %0d clean ends.", sb.n_nodes, sb.n_errors,
			sb.n_ends);
		if (sb.n_failures == 0 && sb.expected_events.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

@@ template_tag_tokenizer_top.f @@
+incdir+rtl/core
rtl/core/ttt_pkg.sv
rtl/core/ttt_if.sv
rtl/core/ttt_scan.sv
rtl/core/ttt_emit.sv
rtl/core/template_tag_tokenizer_top.sv
tb/template_tag_tokenizer_top_tb.sv
